### sv/aics_pkg.sv
// Shared constants and types of the activator-inhibitor stencil unit.
package aics_pkg;

   localparam int GRID_WIDTH  = 128;
   localparam int GRID_HEIGHT = 128;

   localparam int COL_W = $clog2(GRID_WIDTH);
   localparam int ROW_W = $clog2(GRID_HEIGHT + 3);
   localparam int OUT_W = 7;

   localparam int WEIGHT_W = 8;
   localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 8'd32;

   // Past rows held per column in the line memory.
   localparam int HIST = 4;

   localparam int WIN_N    = 5;
   localparam int WIN_BITS = WIN_N * WIN_N;
   localparam int CENTRE_BIT = 12;

   // Bit (dy+2)*5+(dx+2): inner 3x3 ring without the center, and the outer ring.
   localparam logic [WIN_BITS-1:0] ACT_MASK = 25'h00729C0;
   localparam logic [WIN_BITS-1:0] INH_MASK = 25'h1F8C63F;

   localparam int ACT_W = 4;
   localparam int INH_W = 5;
   localparam int CMP_W = 13;

   typedef struct packed {
      logic             has_res;
      logic [ROW_W-1:0] crow;
      logic [COL_W-1:0] ccol;
      logic             last;
   } meta_type;

endpackage

### sv/aics_channels.sv
// Handshake channels of the activator-inhibitor stencil unit.
interface aics_req_chan;
   logic valid;
   logic ready;
   logic cell_in;
   logic flush;
   modport source (output valid, output cell_in, output flush, input ready);
   modport sink (input valid, input cell_in, input flush, output ready);
endinterface

interface aics_rsp_chan;
   logic                      valid;
   logic                      ready;
   logic                      new_cell;
   logic [aics_pkg::OUT_W-1:0] cell_row;
   logic [aics_pkg::OUT_W-1:0] cell_col;
   logic                      frame_last;
   modport source (output valid, output new_cell, output cell_row, output cell_col,
                   output frame_last, input ready);
   modport sink (input valid, input new_cell, input cell_row, input cell_col,
                 input frame_last, output ready);
endinterface

interface aics_csr_chan;
   logic                         valid;
   logic                         ready;
   logic [aics_pkg::WEIGHT_W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

### sv/aics_rule.sv
// Activator/inhibitor count and the weighted compare for one masked 5x5 window.
module aics_rule (
   input  logic [aics_pkg::WIN_BITS-1:0] win,
   input  logic [aics_pkg::WEIGHT_W-1:0] weight,
   output logic                          new_cell
);

   logic [aics_pkg::ACT_W-1:0] acts;
   logic [aics_pkg::INH_W-1:0] inhs;
   logic [aics_pkg::CMP_W-1:0] lhs;
   logic [aics_pkg::CMP_W-1:0] rhs;

   always_comb begin
      acts = aics_pkg::ACT_W'($countones(win & aics_pkg::ACT_MASK));
      inhs = aics_pkg::INH_W'($countones(win & aics_pkg::INH_MASK));
      // Weight is Q4.4: scale the activator count by 16.
      lhs  = aics_pkg::CMP_W'({acts, 4'b0000});
      rhs  = aics_pkg::CMP_W'(inhs) * aics_pkg::CMP_W'(weight);
      if (lhs < rhs) begin
         new_cell = 1'b0;
      end else if (lhs > rhs) begin
         new_cell = 1'b1;
      end else begin
         new_cell = win[aics_pkg::CENTRE_BIT];
      end
   end

endmodule

### sv/activator_inhibitor_ca_stencil_unit.sv
// Top level of the activator-inhibitor cellular automaton stencil unit.
//
// Cells of a 128x128 binary grid enter on req_if in raster order, one item
// per cell; after the last cell the source sends 2*128+2 drain items
// (any value), and a flush item inside the frame is taken and dropped.
// Each rsp_if item carries the next state of one cell with its row and
// column; frame_last marks the final cell of the frame.
// A cell's result leaves with the item that arrives 2*128+2 items after it,
// then passes the line-memory read, window shift and mask, and rule stages.
// Throughput is one item per cycle unless rsp_if stalls: per item, the line
// memory reads column c and writes back column c-1 in the same cycle.
// csr_if writes the inhibitor weight (Q4.4) and is always ready; write it
// only while the block is idle.
// Reset clears the position to row 0, column 0, empties the pipeline and
// sets the weight to 2.0; the line memory is not cleared, rows above the
// grid are masked instead. When rsp_if stalls, the whole pipeline holds and
// req_if.ready drops until the output register is taken.
module activator_inhibitor_ca_stencil_unit (
   input  logic              clock,
   input  logic              reset,
   aics_req_chan.sink        req_if,
   aics_rsp_chan.source      rsp_if,
   aics_csr_chan.sink        csr_if
);

   localparam int RX_W = aics_pkg::ROW_W + 1;
   localparam int CX_W = aics_pkg::COL_W + 1;

   logic adv;
   logic accept;
   logic in_frame;
   logic take;
   logic c_ge2;

   logic [aics_pkg::WEIGHT_W-1:0] weight_ff;
   logic [aics_pkg::ROW_W-1:0]    in_row_ff, in_row_in;
   logic [aics_pkg::COL_W-1:0]    in_col_ff, in_col_in;
   aics_pkg::meta_type            meta_s0;

   logic [aics_pkg::HIST-1:0] line_mem [aics_pkg::GRID_WIDTH];
   logic [aics_pkg::HIST-1:0] rd_data_ff;

   logic                       s1_valid_ff;
   aics_pkg::meta_type         s1_meta_ff;
   logic                       s1_cell_ff;
   logic [aics_pkg::COL_W-1:0] s1_col_ff;

   logic [aics_pkg::WIN_BITS-1:0] win_ff, win_in;
   logic [aics_pkg::WIN_BITS-1:0] win_masked;
   logic [aics_pkg::WIN_N-1:0]    col_new;
   logic [aics_pkg::WIN_N-1:0]    row_ok;
   logic [aics_pkg::WIN_N-1:0]    col_ok;

   logic                          s2_valid_ff;
   aics_pkg::meta_type            s2_meta_ff;
   logic [aics_pkg::WIN_BITS-1:0] s2_win_ff;
   logic                          s2_new_cell;

   logic                       rsp_valid_ff;
   logic                       rsp_new_cell_ff;
   logic [aics_pkg::OUT_W-1:0] rsp_row_ff;
   logic [aics_pkg::OUT_W-1:0] rsp_col_ff;
   logic                       rsp_last_ff;

   assign adv           = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready  = adv;
   assign accept        = req_if.valid && adv;
   assign csr_if.ready  = 1'b1;

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.new_cell   = rsp_new_cell_ff;
   assign rsp_if.cell_row   = rsp_row_ff;
   assign rsp_if.cell_col   = rsp_col_ff;
   assign rsp_if.frame_last = rsp_last_ff;

   // Position of the incoming item and the cell whose result it releases.
   always_comb begin
      in_frame = in_row_ff < aics_pkg::ROW_W'(aics_pkg::GRID_HEIGHT);
      take     = accept && !(in_frame && req_if.flush);
      c_ge2    = in_col_ff >= aics_pkg::COL_W'(2);

      meta_s0.has_res = (in_row_ff > aics_pkg::ROW_W'(2))
                        || ((in_row_ff == aics_pkg::ROW_W'(2)) && c_ge2);
      if (c_ge2) begin
         meta_s0.ccol = in_col_ff - aics_pkg::COL_W'(2);
         meta_s0.crow = in_row_ff - aics_pkg::ROW_W'(2);
      end else begin
         meta_s0.ccol = in_col_ff + aics_pkg::COL_W'(aics_pkg::GRID_WIDTH - 2);
         meta_s0.crow = in_row_ff - aics_pkg::ROW_W'(3);
      end
      meta_s0.last = meta_s0.has_res
                     && (meta_s0.crow == aics_pkg::ROW_W'(aics_pkg::GRID_HEIGHT - 1))
                     && (meta_s0.ccol == aics_pkg::COL_W'(aics_pkg::GRID_WIDTH - 1));

      in_row_in = in_row_ff;
      in_col_in = in_col_ff;
      if (meta_s0.last) begin
         in_row_in = '0;
         in_col_in = '0;
      end else if (in_col_ff == aics_pkg::COL_W'(aics_pkg::GRID_WIDTH - 1)) begin
         in_col_in = '0;
         in_row_in = in_row_ff + aics_pkg::ROW_W'(1);
      end else begin
         in_col_in = in_col_ff + aics_pkg::COL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff <= aics_pkg::WEIGHT_RESET;
      end else if (csr_if.valid) begin
         weight_ff <= csr_if.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_row_ff <= '0;
         in_col_ff <= '0;
      end else if (take) begin
         in_row_ff <= in_row_in;
         in_col_ff <= in_col_in;
      end
   end

   // Line memory: per column, the four rows above the current one.
   always_ff @(posedge clock) begin
      if (adv) begin
         rd_data_ff <= line_mem[in_col_ff];
      end
      if (s1_valid_ff && adv) begin
         line_mem[s1_col_ff] <= {rd_data_ff[aics_pkg::HIST-2:0], s1_cell_ff};
      end
   end

   // Stage 1: memory data is back; shift the window and mask out-of-grid taps.
   always_comb begin
      col_new = {s1_cell_ff, rd_data_ff[0], rd_data_ff[1], rd_data_ff[2], rd_data_ff[3]};
      for (int k = 0; k < aics_pkg::WIN_N; k++) begin
         row_ok[k] = ({1'b0, s1_meta_ff.crow} + RX_W'(k) >= RX_W'(2))
                     && ({1'b0, s1_meta_ff.crow} + RX_W'(k)
                         < RX_W'(aics_pkg::GRID_HEIGHT + 2));
         col_ok[k] = ({1'b0, s1_meta_ff.ccol} + CX_W'(k) >= CX_W'(2))
                     && ({1'b0, s1_meta_ff.ccol} + CX_W'(k)
                         < CX_W'(aics_pkg::GRID_WIDTH + 2));
      end
      for (int k = 0; k < aics_pkg::WIN_N; k++) begin
         for (int j = 0; j < aics_pkg::WIN_N; j++) begin
            if (j == aics_pkg::WIN_N - 1) begin
               win_in[k*aics_pkg::WIN_N + j] = col_new[k];
            end else begin
               win_in[k*aics_pkg::WIN_N + j] = win_ff[k*aics_pkg::WIN_N + j + 1];
            end
            win_masked[k*aics_pkg::WIN_N + j] = win_in[k*aics_pkg::WIN_N + j]
                                                & row_ok[k] & col_ok[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         win_ff       <= '0;
      end else if (adv) begin
         s1_valid_ff  <= take;
         s2_valid_ff  <= s1_valid_ff && s1_meta_ff.has_res;
         rsp_valid_ff <= s2_valid_ff;
         if (s1_valid_ff) begin
            win_ff <= win_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_meta_ff      <= meta_s0;
         s1_cell_ff      <= in_frame ? req_if.cell_in : 1'b0;
         s1_col_ff       <= in_col_ff;
         s2_meta_ff      <= s1_meta_ff;
         s2_win_ff       <= win_masked;
         rsp_new_cell_ff <= s2_new_cell;
         rsp_row_ff      <= s2_meta_ff.crow[aics_pkg::OUT_W-1:0];
         rsp_col_ff      <= s2_meta_ff.ccol[aics_pkg::OUT_W-1:0];
         rsp_last_ff     <= s2_meta_ff.last;
      end
   end

   aics_rule u_rule (
      .win      (s2_win_ff),
      .weight   (weight_ff),
      .new_cell (s2_new_cell)
   );

endmodule

### verif/tb_top.sv
// Self-checking testbench of the activator-inhibitor stencil unit: the opening rows of a frame.
`timescale 1ns / 100ps

module tb_top;

   localparam int IDLE_PCT      = 21;
   localparam int QUIET_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 8;
   localparam int MAX_REPORTS   = 40;
   localparam int LAG_ITEMS     = 2 * aics_pkg::GRID_WIDTH + 2;
   localparam int FRAME_CELLS   = aics_pkg::GRID_WIDTH * aics_pkg::GRID_HEIGHT;
   localparam int RANDOM_CELLS  = 120;
   localparam int CALM_CELLS    = 160;
   localparam int CHUNK_CELLS   = 31;
   localparam int OPENING_CELLS = 18;
   localparam logic [OPENING_CELLS-1:0] OPENING = 18'b10_1100_1110_0101_1011;

   typedef struct packed {
      logic cell_in;
      logic flush;
   } raster_item_type;

   typedef struct packed {
      logic                       new_cell;
      logic [aics_pkg::OUT_W-1:0] cell_row;
      logic [aics_pkg::OUT_W-1:0] cell_col;
      logic                       frame_last;
   } cell_result_type;

   logic clock;
   logic reset;

   aics_req_chan req_ch();
   aics_rsp_chan rsp_ch();
   aics_csr_chan csr_ch();

   activator_inhibitor_ca_stencil_unit DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   raster_item_type raster_items[$];
   cell_result_type future_cells[$];

   // Mirror of the block: five most recent rows, write position, weight.
   bit                            recent_rows[5][aics_pkg::GRID_WIDTH];
   int                            next_row;
   int                            next_col;
   logic [aics_pkg::WEIGHT_W-1:0] weight_now;

   bit calm;
   int bad_count;
   int cells_checked;
   int ties_seen;
   int items_sent;
   int flushes_dropped;
   int weights_written;
   int quiet_cycles;

   function automatic int grid_tap(input int r, input int c);
      if (r < 0 || r >= aics_pkg::GRID_HEIGHT || c < 0 || c >= aics_pkg::GRID_WIDTH)
         return 0;
      return int'(recent_rows[r % 5][c]);
   endfunction

   // Store the item's cell and work out the next state of the cell two rows
   // and two columns back, if that cell lies inside the grid.
   function automatic void predict_next_state(input raster_item_type it);
      int r, c, pos, n, crow, ccol, acts, inhs, ady, adx, ring, v, lhs, rhs;
      logic center;
      cell_result_type res;
      r = next_row;
      c = next_col;
      acts = 0;
      inhs = 0;
      center = 1'b0;
      if (r < aics_pkg::GRID_HEIGHT) begin
         if (it.flush) begin
            flushes_dropped++;
            return;
         end
         recent_rows[r % 5][c] = it.cell_in;
      end
      pos = r * aics_pkg::GRID_WIDTH + c;
      if (c == aics_pkg::GRID_WIDTH - 1) begin
         next_col = 0;
         next_row = r + 1;
      end else begin
         next_col = c + 1;
      end
      if (pos < LAG_ITEMS)
         return;
      n = pos - LAG_ITEMS;
      crow = n / aics_pkg::GRID_WIDTH;
      ccol = n % aics_pkg::GRID_WIDTH;
      for (int dy = -2; dy <= 2; dy++) begin
         for (int dx = -2; dx <= 2; dx++) begin
            v = grid_tap(crow + dy, ccol + dx);
            ady = (dy < 0) ? -dy : dy;
            adx = (dx < 0) ? -dx : dx;
            ring = (ady > adx) ? ady : adx;
            if (ring == 0)
               center = v[0];
            else if (ring == 1)
               acts += v;
            else
               inhs += v;
         end
      end
      lhs = acts * 16;
      rhs = inhs * int'(weight_now);
      if (lhs < rhs) begin
         res.new_cell = 1'b0;
      end else if (lhs > rhs) begin
         res.new_cell = 1'b1;
      end else begin
         res.new_cell = center;
         ties_seen++;
      end
      res.cell_row = aics_pkg::OUT_W'(crow);
      res.cell_col = aics_pkg::OUT_W'(ccol);
      res.frame_last = (n == FRAME_CELLS - 1);
      if (res.frame_last) begin
         next_row = 0;
         next_col = 0;
      end
      future_cells.push_back(res);
   endfunction

   function automatic void check_field(input string what, input int want_v, input int got_v,
                                       input cell_result_type want);
      if (want_v != got_v) begin
         bad_count++;
         if (bad_count <= MAX_REPORTS)
            $display("%0t: %s expected %0d actual %0d (cell %0d,%0d)", $time, what,
                     want_v, got_v, want.cell_row, want.cell_col);
      end
   endfunction

   task automatic push_item(input logic cell_in, input logic flush);
      raster_item_type it;
      it.cell_in = cell_in;
      it.flush = flush;
      raster_items.push_back(it);
   endtask

   // Queue cells at the given density, with flush items mixed in as noise.
   task automatic queue_cells(input int count, input int density, input int noise_pct);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(99) < noise_pct)
            push_item(1'($urandom_range(1)), 1'b1);
         push_item($urandom_range(99) < density, 1'b0);
      end
   endtask

   // Hold the sender until every expected result is out and the pipe is quiet.
   task automatic settle();
      while (raster_items.size() > 0 || req_ch.valid || future_cells.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_weight(input logic [aics_pkg::WEIGHT_W-1:0] w);
      @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.data <= w;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      weight_now = w;
      weights_written++;
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Driver: advance to the next item once the current one is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.cell_in <= 1'b0;
         req_ch.flush <= 1'b0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (raster_items.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
            req_ch.valid <= 1'b1;
            {req_ch.cell_in, req_ch.flush} <= raster_items.pop_front();
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      rsp_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
   end

   // Monitor: predict on every accepted item, check every accepted result.
   always @(posedge clock) begin
      cell_result_type want;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            items_sent++;
            predict_next_state('{cell_in: req_ch.cell_in, flush: req_ch.flush});
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (future_cells.size() == 0) begin
               bad_count++;
               if (bad_count <= MAX_REPORTS)
                  $display("%0t: result with none expected: new_cell %0d row %0d col %0d",
                           $time, rsp_ch.new_cell, rsp_ch.cell_row, rsp_ch.cell_col);
            end else begin
               want = future_cells.pop_front();
               cells_checked++;
               check_field("new_cell", want.new_cell, rsp_ch.new_cell, want);
               check_field("cell_row", want.cell_row, rsp_ch.cell_row, want);
               check_field("cell_col", want.cell_col, rsp_ch.cell_col, want);
               check_field("frame_last", want.frame_last, rsp_ch.frame_last, want);
            end
         end
      end
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
   end

   initial begin
      while (quiet_cycles < QUIET_LIMIT)
         @(posedge clock);
      $display("%0t: no handshake for %0d cycles, %0d results outstanding",
               $time, QUIET_LIMIT, future_cells.size());
      $display("tb_top: errors");
      $finish;
   end

   initial begin
      int density[8];
      logic [aics_pkg::WEIGHT_W-1:0] chunk_weight[8];
      density = '{50, 85, 15, 60, 50, 35, 95, 50};
      chunk_weight = '{aics_pkg::WEIGHT_RESET, 8'd0, 8'd255, 8'd16,
                       8'($urandom_range(255)), 8'd1, 8'd32, 8'($urandom_range(255))};
      reset = 1'b1;
      csr_ch.valid = 1'b0;
      csr_ch.data = '0;
      calm = 1'b0;
      weight_now = aics_pkg::WEIGHT_RESET;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Opening: fixed cells, with flush items inside the frame that must be dropped.
      for (int i = 0; i < OPENING_CELLS; i++) begin
         if (i % 9 == 0)
            push_item(~OPENING[i], 1'b1);
         push_item(OPENING[i], 1'b0);
      end
      queue_cells(RANDOM_CELLS - OPENING_CELLS, 50, 3);

      // Run a stretch with no idling on either side.
      settle();
      calm = 1'b1;
      queue_cells(CALM_CELLS, 60, 3);
      settle();
      calm = 1'b0;

      // Short stretches, each under its own weight.
      for (int k = 0; k < 8; k++) begin
         settle();
         write_weight(chunk_weight[k]);
         queue_cells(CHUNK_CELLS, density[k], 3);
      end

      while (raster_items.size() > 0 || req_ch.valid || future_cells.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES + 4) @(posedge clock);
      if (future_cells.size() > 0)
         bad_count++;

      $display("tb_top: %0d items accepted, %0d flush items dropped inside the frame",
               items_sent, flushes_dropped);
      $display("tb_top: %0d cell results checked over %0d weight writes, %0d settled by a tie",
               cells_checked, weights_written, ties_seen);
      if (bad_count == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

endmodule

### files.f
sv/aics_pkg.sv
sv/aics_channels.sv
sv/aics_rule.sv
sv/activator_inhibitor_ca_stencil_unit.sv
verif/tb_top.sv
